[rtl/kwcb_pkg.sv]
package kwcb_pkg;

    localparam int DATA_W = 32;
    localparam int LIMIT_W = 31;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_COALESCE_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_LIMIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_LOW_BOUND  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_HIGH_BOUND = 2'd3;

    // Reset values of the configuration registers.
    localparam logic               RST_COALESCE_ENABLE = 1'b1;
    localparam logic [LIMIT_W-1:0] RST_FIELD_LIMIT     = 31'h0000_0040;
    localparam logic [DATA_W-1:0]  RST_UNIT_LOW_BOUND  = 32'h0001_0000;
    localparam logic [DATA_W-1:0]  RST_UNIT_HIGH_BOUND = 32'hFFE0_0000;

    // Result kinds.
    localparam logic [1:0] KIND_UPDATE = 2'd0;
    localparam logic [1:0] KIND_ENTRY  = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    // Operation codes of an input item.
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_FILL,
        S_REPLY,
        S_END
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] unit;
        logic [DATA_W-1:0] field;
        logic [DATA_W-1:0] value;
    } t_slot;

    typedef struct packed {
        logic               coalesce_enable;
        logic [LIMIT_W-1:0] field_limit;
        logic [DATA_W-1:0]  unit_low_bound;
        logic [DATA_W-1:0]  unit_high_bound;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        kind;
        logic              accepted;
        logic [DATA_W-1:0] unit;
        logic [DATA_W-1:0] field;
        logic [DATA_W-1:0] value;
        logic              last;
    } t_result;

endpackage

[rtl/kwcb_slot_mem.sv]
module kwcb_slot_mem
    import kwcb_pkg::*;
#(
    parameter int ENTRIES = 32,
    parameter int AW = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_slot         i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_slot         o_rdata
);

    t_slot r_mem [ENTRIES];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/kwcb_seq.sv]
module kwcb_seq
    import kwcb_pkg::*;
#(
    parameter int ENTRIES = 32,
    parameter int AW = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_start,
    input  logic              i_operation,
    input  logic [DATA_W-1:0] i_unit,
    input  logic [DATA_W-1:0] i_field,
    input  logic [DATA_W-1:0] i_value,
    output logic              o_busy,
    input  logic              i_out_free,
    output logic              o_emit,
    output t_result           o_result,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output t_slot             o_wdata,
    output logic              o_re,
    output logic [AW-1:0]     o_raddr,
    input  t_slot             i_rdata
);

    t_state             r_state, n_state;
    logic               r_op, n_op;
    logic [DATA_W-1:0]  r_unit, n_unit;
    logic [DATA_W-1:0]  r_field, n_field;
    logic [DATA_W-1:0]  r_value, n_value;
    logic [AW-1:0]      r_idx, n_idx;
    logic               r_free_ok, n_free_ok;
    logic [AW-1:0]      r_free_idx, n_free_idx;
    logic               r_ok, n_ok;
    logic [ENTRIES-1:0] r_valid, n_valid;

    logic eligible;
    logic key_match;
    logic in_bounds;
    logic idx_last;
    logic cur_valid;

    // The field id is signed and the limit is not, so any negative id lies below it.
    assign eligible = i_cfg.coalesce_enable &&
                      (i_field[DATA_W-1] || (i_field[LIMIT_W-1:0] < i_cfg.field_limit));

    assign key_match = (i_rdata.unit == r_unit) && (i_rdata.field == r_field);
    assign in_bounds = (i_rdata.unit > i_cfg.unit_low_bound) &&
                       (i_rdata.unit < i_cfg.unit_high_bound);
    assign idx_last  = (r_idx == AW'(ENTRIES - 1));
    assign cur_valid = r_valid[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_free_ok <= 1'b0;
            r_ok      <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_free_ok <= n_free_ok;
            r_ok      <= n_ok;
            r_idx     <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_unit     <= n_unit;
        r_field    <= n_field;
        r_value    <= n_value;
        r_free_idx <= n_free_idx;
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_unit     = r_unit;
        n_field    = r_field;
        n_value    = r_value;
        n_idx      = r_idx;
        n_free_ok  = r_free_ok;
        n_free_idx = r_free_idx;
        n_ok       = r_ok;
        n_valid    = r_valid;
        o_emit     = 1'b0;
        o_result   = '0;
        o_we       = 1'b0;
        o_waddr    = r_idx;
        o_wdata    = '{unit: r_unit, field: r_field, value: r_value};
        o_re       = 1'b0;
        o_raddr    = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op      = i_operation;
                    n_unit    = i_unit;
                    n_field   = i_field;
                    n_value   = i_value;
                    n_idx     = '0;
                    n_free_ok = 1'b0;
                    n_ok      = 1'b0;
                    if (i_operation == OP_FLUSH || eligible) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_REPLY;
                    end
                end
            end
            S_RD: begin
                o_re    = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_op == OP_UPDATE) begin
                    if (cur_valid && key_match) begin
                        // Same key already pending: overwrite its value in place.
                        o_we    = 1'b1;
                        n_ok    = 1'b1;
                        n_state = S_REPLY;
                    end else begin
                        if (!cur_valid && !r_free_ok) begin
                            n_free_ok  = 1'b1;
                            n_free_idx = r_idx;
                        end
                        if (idx_last) begin
                            n_state = S_FILL;
                        end else begin
                            n_idx   = r_idx + 1'b1;
                            n_state = S_RD;
                        end
                    end
                end else begin
                    if (!(cur_valid && in_bounds) || i_out_free) begin
                        if (cur_valid && in_bounds) begin
                            o_emit   = 1'b1;
                            o_result = '{kind: KIND_ENTRY, accepted: 1'b0,
                                         unit: i_rdata.unit, field: i_rdata.field,
                                         value: i_rdata.value, last: 1'b0};
                        end
                        n_valid[r_idx] = 1'b0;
                        if (idx_last) begin
                            n_state = S_END;
                        end else begin
                            n_idx   = r_idx + 1'b1;
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_FILL: begin
                if (r_free_ok) begin
                    o_we                = 1'b1;
                    o_waddr             = r_free_idx;
                    n_valid[r_free_idx] = 1'b1;
                    n_ok                = 1'b1;
                end else begin
                    n_ok = 1'b0;
                end
                n_state = S_REPLY;
            end
            S_REPLY: begin
                if (i_out_free) begin
                    o_emit   = 1'b1;
                    o_result = '{kind: KIND_UPDATE, accepted: r_ok, unit: '0,
                                 field: '0, value: '0, last: 1'b1};
                    n_state  = S_IDLE;
                end
            end
            S_END: begin
                if (i_out_free) begin
                    o_emit   = 1'b1;
                    o_result = '{kind: KIND_END, accepted: 1'b0, unit: '0,
                                 field: '0, value: '0, last: 1'b1};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[rtl/keyed_write_coalescing_buffer.sv]
// Keyed write-coalescing buffer. An update item (operation 0) carries a unit
// handle, a field id and a value; when coalescing is enabled and the signed field
// id is below field_limit, the value overwrites a pending entry with the same unit
// and field, or else takes the lowest free slot. Exactly one reply follows, with
// accepted set when the update was absorbed and cleared when coalescing is off,
// the field id is too large or the table is full. A flush item (operation 1) walks
// the slots in order, sends one entry item for every pending slot whose unit lies
// strictly between unit_low_bound and unit_high_bound, drops the rest, empties the
// table and ends with an end marker; last is set only on the reply or the marker.
// Slot contents live in a single-port-read memory, so the sequencer handles the
// slots one at a time, first addressing a slot and then comparing it. An update
// reply, a flush entry and the end marker each wait while the output side stalls.
// The block takes one item at a time and holds o_stall high until that item's
// last result has been registered. A result sits in an output register, so the
// next item can be accepted while the previous result still waits to be taken.
// Configuration writes are expected only while the block is idle.
module keyed_write_coalescing_buffer
    import kwcb_pkg::*;
#(
    parameter int ENTRIES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    // Input channel.
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_operation,
    input  logic [DATA_W-1:0]    i_unit_handle,
    input  logic signed [DATA_W-1:0] i_field_id,
    input  logic signed [DATA_W-1:0] i_new_value,
    // Output channel.
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_kind,
    output logic                 o_accepted,
    output logic [DATA_W-1:0]    o_out_unit,
    output logic signed [DATA_W-1:0] o_out_field,
    output logic signed [DATA_W-1:0] o_out_value,
    output logic                 o_last
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    t_cfg    r_cfg;
    logic    r_o_valid;
    t_result r_out;

    logic    busy;
    logic    start;
    logic    out_free;
    logic    emit;
    t_result result;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_slot         mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    t_slot         mem_rdata;

    // Configuration registers. Every index of the port names a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coalesce_enable <= RST_COALESCE_ENABLE;
            r_cfg.field_limit     <= RST_FIELD_LIMIT;
            r_cfg.unit_low_bound  <= RST_UNIT_LOW_BOUND;
            r_cfg.unit_high_bound <= RST_UNIT_HIGH_BOUND;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COALESCE_ENABLE: r_cfg.coalesce_enable <= i_cfg_data[0];
                CFG_FIELD_LIMIT:     r_cfg.field_limit     <= i_cfg_data[LIMIT_W-1:0];
                CFG_UNIT_LOW_BOUND:  r_cfg.unit_low_bound  <= i_cfg_data;
                CFG_UNIT_HIGH_BOUND: r_cfg.unit_high_bound <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_stall  = busy;
    assign start    = i_valid && !busy;

    // The output register can load whenever it is empty or being emptied this cycle.
    assign out_free = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= result;
        end
    end

    kwcb_slot_mem #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    kwcb_seq #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start     (start),
        .i_operation (i_operation),
        .i_unit      (i_unit_handle),
        .i_field     (i_field_id),
        .i_value     (i_new_value),
        .o_busy      (busy),
        .i_out_free  (out_free),
        .o_emit      (emit),
        .o_result    (result),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_re        (mem_re),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata)
    );

    assign o_valid     = r_o_valid;
    assign o_kind      = r_out.kind;
    assign o_accepted  = r_out.accepted;
    assign o_out_unit  = r_out.unit;
    assign o_out_field = r_out.field;
    assign o_out_value = r_out.value;
    assign o_last      = r_out.last;

endmodule
